// ===== rtl/core/rbd_pkg.sv =====
// rbd_pkg: shared types, constants and the premultiply helper
// used by every module of the rgba box downsampler; no dependencies
package rbd_pkg;

    localparam int PIX_W   = 8;   // channel width
    localparam int POS_W   = 8;   // widest output position (up to 256 columns)
    localparam int FLD_W   = 5;   // width of the column and row result fields
    localparam int DIVD_W  = 16;  // divider dividend width
    localparam int QUO_W   = 8;   // divider quotient width
    localparam int LANES   = 4;   // red, green, blue, alpha

    localparam int LANE_R  = 0;
    localparam int LANE_G  = 1;
    localparam int LANE_B  = 2;
    localparam int LANE_A  = 3;

    localparam logic [15:0] PM_ROUND = 16'd127;

    // one source pixel after classification, as held in the queue
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             dx_first;
        logic             dx_last;
        logic             dy_first;
        logic             dy_last;
        logic             frame_end;
    } t_pix;

    // one downsampled pixel
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
        logic [FLD_W-1:0] col;
        logic [FLD_W-1:0] row;
        logic             frame_end;
    } t_res;

    // (c*a+127)/255, divide by 255 as (x + (x>>8) + 1) >> 8, exact below 65535
    function automatic logic [PIX_W-1:0] premultiply(input logic [PIX_W-1:0] c,
                                                      input logic [PIX_W-1:0] a);
        logic [15:0] prod;
        logic [16:0] acc;
        prod = (16'(c) * 16'(a)) + PM_ROUND;
        acc  = 17'(prod) + 17'(prod[15:8]) + 17'd1;
        return acc[15:8];
    endfunction

endpackage

// ===== rtl/core/rbd_front.sv =====
// rbd_front: source position counters, optional premultiply and pixel classification
// depends on rbd_pkg
module rbd_front #(
    parameter int OUT_SIZE = 32,
    parameter int SCALE    = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic                       i_premul,
    input  logic [rbd_pkg::PIX_W-1:0]  i_red,
    input  logic [rbd_pkg::PIX_W-1:0]  i_green,
    input  logic [rbd_pkg::PIX_W-1:0]  i_blue,
    input  logic [rbd_pkg::PIX_W-1:0]  i_alpha,
    output rbd_pkg::t_pix              o_item
);
    import rbd_pkg::*;

    localparam int D_W = (SCALE > 1) ? $clog2(SCALE) : 1;
    localparam int C_W = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
    localparam logic [D_W-1:0] D_MAX = D_W'(SCALE - 1);
    localparam logic [C_W-1:0] C_MAX = C_W'(OUT_SIZE - 1);

    logic [D_W-1:0] r_dx, r_dy;
    logic [C_W-1:0] r_col, r_row;
    logic [D_W-1:0] n_dx, n_dy;
    logic [C_W-1:0] n_col, n_row;
    logic           dx_last, dy_last, col_last, row_last;

    assign dx_last  = (r_dx == D_MAX);
    assign dy_last  = (r_dy == D_MAX);
    assign col_last = (r_col == C_MAX);
    assign row_last = (r_row == C_MAX);

    // raster walk: dx inside the block, then column, then dy, then row
    always_comb begin
        n_dx  = r_dx;
        n_col = r_col;
        n_dy  = r_dy;
        n_row = r_row;
        if (dx_last) begin
            n_dx = '0;
            if (col_last) begin
                n_col = '0;
                if (dy_last) begin
                    n_dy  = '0;
                    n_row = row_last ? '0 : r_row + 1'b1;
                end else begin
                    n_dy = r_dy + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end else begin
            n_dx = r_dx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dx  <= '0;
            r_dy  <= '0;
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_comb begin
        o_item.red       = i_premul ? i_red   : premultiply(i_red,   i_alpha);
        o_item.green     = i_premul ? i_green : premultiply(i_green, i_alpha);
        o_item.blue      = i_premul ? i_blue  : premultiply(i_blue,  i_alpha);
        o_item.alpha     = i_alpha;
        o_item.col       = POS_W'(r_col);
        o_item.row       = POS_W'(r_row);
        o_item.dx_first  = (r_dx == '0);
        o_item.dx_last   = dx_last;
        o_item.dy_first  = (r_dy == '0);
        o_item.dy_last   = dy_last;
        o_item.frame_end = dx_last && dy_last && col_last && row_last;
    end

endmodule

// ===== rtl/core/rbd_fifo.sv =====
// rbd_fifo: short queue of classified pixels between front and back
// depends on rbd_pkg
module rbd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rbd_pkg::t_pix i_data,
    output logic          o_full,
    input  logic          i_pop,
    output rbd_pkg::t_pix o_data,
    output logic          o_empty
);
    import rbd_pkg::*;

    localparam int A_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int N_W = $clog2(DEPTH + 1);
    localparam logic [A_W-1:0] A_MAX = A_W'(DEPTH - 1);
    localparam logic [N_W-1:0] N_FULL = N_W'(DEPTH);

    t_pix           mem [DEPTH];
    logic [A_W-1:0] r_wp, r_rp;
    logic [N_W-1:0] r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == N_FULL);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == A_MAX) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == A_MAX) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push && !do_pop |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count did not rise on push");

endmodule

// ===== rtl/core/rbd_div.sv =====
// rbd_div: iterative restoring divider, 16-bit dividend, 8-bit quotient
// quotients of 256 and above saturate to 255; depends on rbd_pkg
module rbd_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rbd_pkg::DIVD_W-1:0]  i_dividend,
    input  logic [rbd_pkg::PIX_W-1:0]   i_divisor,
    output logic [rbd_pkg::QUO_W-1:0]   o_quo,
    output logic                        o_done
);
    import rbd_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic [DIVD_W-1:0] r_rem, r_dsr;
    logic [QUO_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy, r_sat, r_done;
    logic              ge;

    assign ge     = (r_rem >= r_dsr);
    assign o_quo  = r_sat ? '1 : r_quo;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // fixed run length, saturation only swaps the answer
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_dsr <= {1'b0, i_divisor, 7'b0};
            r_quo <= '0;
            r_cnt <= CNT_W'(QUO_W - 1);
            r_sat <= (i_dividend >= {i_divisor, 8'b0});
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsr;
            end
            r_quo <= {r_quo[QUO_W-2:0], ge};
            r_dsr <= r_dsr >> 1;
            r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ===== rtl/core/rbd_back.sv =====
// rbd_back: column accumulation, averaging and un-premultiply sequencer
// holds the column sum memory and the result register; depends on rbd_pkg, rbd_div
module rbd_back #(
    parameter int OUT_SIZE = 32,
    parameter int SCALE    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rbd_pkg::t_pix i_item,
    input  logic          i_item_valid,
    output logic          o_item_take,
    output rbd_pkg::t_res o_res,
    output logic          o_res_valid,
    input  logic          i_res_take
);
    import rbd_pkg::*;

    localparam int N     = SCALE * SCALE;
    localparam int SUM_W = $clog2(255 * N + 1);
    localparam int C_W   = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
    localparam int CLR   = LANE_A;   // colour lanes sit below alpha
    localparam logic [DIVD_W-1:0] HALF_N = DIVD_W'(N / 2);
    // rounded average by reciprocal multiply, exact for any 16-bit sum
    localparam int     REC_SH = DIVD_W + $clog2(N);
    localparam int     REC_W  = DIVD_W + 2;
    localparam int     PRD_W  = DIVD_W + REC_W;
    localparam longint REC_ML = ((longint'(1) << REC_SH) + longint'(N) - 1) / longint'(N);
    localparam logic [REC_W-1:0] REC_M = REC_W'(REC_ML);

    typedef enum logic [2:0] {S_ACC, S_RMW, S_AVG, S_DIVA, S_OUT} t_state;
    typedef logic [LANES-1:0][SUM_W-1:0] t_sums;

    t_state                    r_state;
    t_sums                     mem [OUT_SIZE];
    t_sums                     r_hacc, r_tot, r_rd;
    t_sums                     hsum, tot;
    logic [LANES-1:0][PIX_W-1:0] pix;
    logic [LANES-1:0][PRD_W-1:0] avg_prod;
    logic [CLR-1:0][PIX_W-1:0] r_avg;
    logic [PIX_W-1:0]          r_alpha;
    logic [POS_W-1:0]          r_col, r_row;
    logic                      r_fend, r_dylast, r_start;
    t_res                      r_out;
    logic                      r_out_valid;
    logic                      take, mem_we, mem_re;
    logic [C_W-1:0]            mem_wa, mem_ra;
    t_sums                     mem_wd;
    logic [CLR-1:0][DIVD_W-1:0] dvd;
    logic [CLR-1:0][QUO_W-1:0] quo;
    logic [CLR-1:0]            done;

    assign take        = (r_state == S_ACC) && i_item_valid;
    assign o_item_take = take;
    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

    assign pix[LANE_R] = i_item.red;
    assign pix[LANE_G] = i_item.green;
    assign pix[LANE_B] = i_item.blue;
    assign pix[LANE_A] = i_item.alpha;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            hsum[l] = (i_item.dx_first ? '0 : r_hacc[l]) + SUM_W'(pix[l]);
            tot[l]  = r_rd[l] + r_hacc[l];
        end
    end

    // memory ports: first band row writes, later rows read then write back
    always_comb begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_wa = r_col[C_W-1:0];
        mem_ra = i_item.col[C_W-1:0];
        mem_wd = tot;
        if (take && i_item.dx_last) begin
            if (i_item.dy_first) begin
                mem_we = 1'b1;
                mem_wa = i_item.col[C_W-1:0];
                mem_wd = hsum;
            end else begin
                mem_re = 1'b1;
            end
        end else if (r_state == S_RMW) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= mem[mem_ra];
        end
    end

    // block averages: (sum + N/2) * ceil(2^REC_SH / N) >> REC_SH
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            avg_prod[l] = PRD_W'(DIVD_W'(r_tot[l]) + HALF_N) * PRD_W'(REC_M);
        end
    end

    // divider lanes: averaged colour back to straight alpha
    always_comb begin
        for (int l = 0; l < CLR; l++) begin
            dvd[l] = {r_avg[l], 8'b0} - DIVD_W'(r_avg[l]) + DIVD_W'(r_alpha >> 1);
        end
    end

    for (genvar g = 0; g < CLR; g++) begin : g_div
        rbd_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (r_start),
            .i_dividend (dvd[g]),
            .i_divisor  (r_alpha),
            .o_quo      (quo[g]),
            .o_done     (done[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= (r_state == S_AVG);
            if (r_state == S_OUT && (!r_out_valid || i_res_take)) begin
                r_out_valid <= 1'b1;
            end else if (i_res_take) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_ACC: begin
                    if (take) begin
                        r_hacc <= hsum;
                        if (i_item.dx_last) begin
                            r_col    <= i_item.col;
                            r_row    <= i_item.row;
                            r_fend   <= i_item.frame_end;
                            r_dylast <= i_item.dy_last;
                            if (!i_item.dy_first) begin
                                r_state <= S_RMW;
                            end else if (i_item.dy_last) begin
                                r_tot   <= hsum;
                                r_state <= S_AVG;
                            end
                        end
                    end
                end
                S_RMW: begin
                    if (r_dylast) begin
                        r_tot   <= tot;
                        r_state <= S_AVG;
                    end else begin
                        r_state <= S_ACC;
                    end
                end
                S_AVG: begin
                    for (int l = 0; l < CLR; l++) begin
                        r_avg[l] <= avg_prod[l][REC_SH +: PIX_W];
                    end
                    r_alpha <= avg_prod[LANE_A][REC_SH +: PIX_W];
                    r_state <= S_DIVA;
                end
                S_DIVA: begin
                    if (done[0]) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // quotients hold until the next start, so load once the slot is free
                    if (!r_out_valid || i_res_take) begin
                        // zero alpha gives black
                        r_out.red   <= (r_alpha == '0) ? '0 : quo[LANE_R];
                        r_out.green <= (r_alpha == '0) ? '0 : quo[LANE_G];
                        r_out.blue  <= (r_alpha == '0) ? '0 : quo[LANE_B];
                        r_out.alpha <= r_alpha;
                        r_out.col   <= r_col[FLD_W-1:0];
                        r_out.row   <= r_row[FLD_W-1:0];
                        r_out.frame_end <= r_fend;
                        r_state     <= S_ACC;
                    end
                end
                default: begin
                    r_state <= S_ACC;
                end
            endcase
        end
    end

    a_rmw_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RMW |-> $past(r_state) == S_ACC)
        else $error("read-modify-write not entered from accumulate");

    a_lanes_together: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done[0] |-> done == '1)
        else $error("divider lanes out of step");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_ACC |-> !o_item_take)
        else $error("item taken while sequencer busy");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_res_take |=> r_out_valid && $stable(r_out))
        else $error("waiting result changed before it was taken");

endmodule

// ===== rtl/core/rgba_box_downsample_unpremultiply.sv =====
// rgba_box_downsample_unpremultiply: top level, configuration register and wiring
// depends on rbd_pkg, rbd_front, rbd_fifo, rbd_back
//
// Source pixels enter through a queue-style port: a request is taken on a rising edge
// with push high and full low, in raster order over a square image of OUT_SIZE*SCALE
// pixels a side. Each SCALE by SCALE block gives one straight-alpha result, offered
// while empty is low and taken on an edge with pop high.
// The input_premultiplied register (byte address 0, reset 1) selects premultiplied
// source colour; when cleared each colour is premultiplied by its alpha on entry.
// Each pixel passes through the accumulator; the last pixel of each block row after
// the first band row also passes through the column memory read-modify-write.
// The last pixel of a block then leads to the rounded averages (reciprocal multiply),
// un-premultiply in three iterative dividers and the load of the result register;
// the back takes no new pixel from the queue until that result is loaded.
// A four-entry request queue sits between the classifying front and the accumulating
// back, so input is still taken while the back divides or a result waits, until the queue fills.
// When the receiver stalls the result register holds and the back stops before the
// next result, after which the queue fills and full rises.
// Reset clears position counters, queue and result valid flag; column sums need no
// clearing: the last pixel of each block's first row writes its entry before any read.
module rgba_box_downsample_unpremultiply #(
    parameter int OUT_SIZE = 32,
    parameter int SCALE    = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // pixel input
    input  logic                      push,
    output logic                      full,
    input  logic [rbd_pkg::PIX_W-1:0] i_src_red,
    input  logic [rbd_pkg::PIX_W-1:0] i_src_green,
    input  logic [rbd_pkg::PIX_W-1:0] i_src_blue,
    input  logic [rbd_pkg::PIX_W-1:0] i_src_alpha,
    // result output
    output logic                      empty,
    input  logic                      pop,
    output logic [rbd_pkg::PIX_W-1:0] o_out_red,
    output logic [rbd_pkg::PIX_W-1:0] o_out_green,
    output logic [rbd_pkg::PIX_W-1:0] o_out_blue,
    output logic [rbd_pkg::PIX_W-1:0] o_out_alpha,
    output logic [rbd_pkg::FLD_W-1:0] o_out_col,
    output logic [rbd_pkg::FLD_W-1:0] o_out_row,
    output logic                      o_frame_end,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import rbd_pkg::*;

    localparam int QDEPTH = 4;

    logic  r_premul;
    logic  accept, q_empty, q_pop, res_valid;
    t_pix  front_item, q_item;
    t_res  res;

    // register 0 is input_premultiplied, other word addresses read as zero
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {31'd0, r_premul};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_premul <= 1'b1;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_premul <= pwdata[0];
        end
    end

    // a request is taken whenever the queue has room
    assign accept = push && !full;

    rbd_front #(
        .OUT_SIZE (OUT_SIZE),
        .SCALE    (SCALE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_premul (r_premul),
        .i_red    (i_src_red),
        .i_green  (i_src_green),
        .i_blue   (i_src_blue),
        .i_alpha  (i_src_alpha),
        .o_item   (front_item)
    );

    rbd_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_item),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_item),
        .o_empty (q_empty)
    );

    rbd_back #(
        .OUT_SIZE (OUT_SIZE),
        .SCALE    (SCALE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (q_item),
        .i_item_valid (!q_empty),
        .o_item_take  (q_pop),
        .o_res        (res),
        .o_res_valid  (res_valid),
        .i_res_take   (pop)
    );

    // result register drives the output side directly
    assign empty       = !res_valid;
    assign o_out_red   = res.red;
    assign o_out_green = res.green;
    assign o_out_blue  = res.blue;
    assign o_out_alpha = res.alpha;
    assign o_out_col   = res.col;
    assign o_out_row   = res.row;
    assign o_frame_end = res.frame_end;

endmodule
